### design/constrained_kruskal_mst_top_defines.svh
// Assertion macros for the constrained MST block.
// Used by constrained_kruskal_mst_top; no other dependencies.
`ifndef CONSTRAINED_KRUSKAL_MST_TOP_DEFINES_SVH
`define CONSTRAINED_KRUSKAL_MST_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define CKM_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CKM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### design/ckm_pkg.sv
// Shared types and constants for the constrained MST block.
// No dependencies.
package ckm_pkg;
  localparam int MaxVertices = 64;
  localparam int MaxEdges    = 64;
  localparam int WeightBits  = 32;
  localparam int VW = 7;   // vertex id width
  localparam int SW = 6;   // slot width
  localparam int CW = 40;  // cost width
  localparam int MaxResults = 64;

  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatCycle  = 2'd1;
  localparam logic [1:0] StatNoSpan = 2'd2;

  localparam logic OpLoad = 1'b0;
  localparam logic OpRun  = 1'b1;

  localparam logic CfgVertexCount = 1'b0;
  localparam logic CfgEdgeCount   = 1'b1;

  typedef struct packed {
    logic                         opcode;
    logic [SW-1:0]                slot;
    logic [VW-1:0]                end_a;
    logic [VW-1:0]                end_b;
    logic signed [WeightBits-1:0] weight;
    logic                         must_use;
    logic                         excluded;
  } in_word_t;

  typedef struct packed {
    logic [SW-1:0]         edge_slot;
    logic signed [CW-1:0]  total_cost;
    logic [1:0]            status;
    logic                  last;
  } out_word_t;
endpackage

### design/ckm_if.sv
// Valid/ready channel interfaces for the constrained MST block.
// Depends on ckm_pkg.
interface ckm_in_if;
  logic              valid;
  logic              ready;
  ckm_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ckm_out_if;
  logic               valid;
  logic               ready;
  ckm_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/constrained_kruskal_mst_top.sv
// Channel     | dir | payload
// in          | in  | opcode, slot, end_a, end_b, weight, must_use, excluded
// out         | out | edge_slot, total_cost, status, last
// cfg         | in  | cfg_we, cfg_index (1 bit), cfg_data (7 bits)
// A load word is written to its slot. A run word starts a clear of all 65 union-find
// entries, then two passes over the edge slots (forced, then free), each ending in a
// fetch that finds the index at the edge count. Every slot passes a fetch and a check
// state; a kept edge adds two find walks, each a climb and a compressing pass waiting
// on every parent read, then a union and, if the roots differ, an emit. Reset (rst_n,
// synchronous) clears control only; in_ready is low while a run works or a word waits
// at out, and a stalled out holds the sequencer only in a state that sends a word.
// Depends on ckm_pkg, ckm_if and constrained_kruskal_mst_top_defines.svh.
`include "constrained_kruskal_mst_top_defines.svh"
module constrained_kruskal_mst_top (
  input  logic clk,
  input  logic rst_n,
  ckm_in_if.sink    in_ch,
  ckm_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);
  localparam int VW = ckm_pkg::VW;
  localparam int SW = ckm_pkg::SW;
  localparam int CW = ckm_pkg::CW;
  localparam int WB = ckm_pkg::WeightBits;
  localparam logic signed [CW-1:0] CostMax = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CostMin = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_FETCH, S_EDGE, S_FIND_UP, S_FIND_CMP, S_UNION, S_EMIT, S_SUM,
    S_WAIT
  } state_t;

  // edge store
  logic [VW-1:0]        ea_mem [ckm_pkg::MaxEdges];
  logic [VW-1:0]        eb_mem [ckm_pkg::MaxEdges];
  logic signed [WB-1:0] w_mem  [ckm_pkg::MaxEdges];
  logic                 f_mem  [ckm_pkg::MaxEdges];
  logic                 b_mem  [ckm_pkg::MaxEdges];
  // union-find store
  logic [VW-1:0]        par_mem  [ckm_pkg::MaxVertices+1];
  logic [VW-1:0]        size_mem [ckm_pkg::MaxVertices+1];

  state_t               state_r;
  logic [VW-1:0]        vcount_r, ecount_r;
  logic [VW-1:0]        nv_r;
  logic [VW-1:0]        ne_r;
  logic [SW:0]          idx_r;       // slot counter, wide enough for the count
  logic                 pass_r;      // 0 forced pass, 1 free pass
  logic [VW-1:0]        eb_r;
  logic signed [WB-1:0] w_r;
  logic                 which_r;     // 0 walking a, 1 walking b
  logic [VW-1:0]        cur_r, start_r, root_a_r;
  logic                 rd_wait_r;   // parent read for cur_r not back yet
  logic signed [CW-1:0] cost_r;
  logic [VW-1:0]        tcount_r;
  logic [SW:0]          nout_r;
  logic                 out_valid_r;
  ckm_pkg::out_word_t   out_r;

  // registered store reads
  logic [VW-1:0]        ea_q_r, eb_q_r;
  logic signed [WB-1:0] w_q_r;
  logic                 f_q_r, b_q_r;
  logic [VW-1:0]        par_q_r, sa_q_r, sb_q_r;

  logic signed [CW:0]   csum;
  logic [SW-1:0]        slot_i;
  logic                 out_free;
  logic                 cycle_hit;
  logic                 emit_go;

  assign in_ch.ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;
  assign slot_i       = idx_r[SW-1:0];
  assign csum         = {cost_r[CW-1], cost_r} + {{(CW+1-WB){w_r[WB-1]}}, w_r};
  assign out_free     = !out_valid_r || out_ch.ready;
  assign cycle_hit    = (state_r == S_UNION) && (root_a_r == start_r) && !pass_r;
  assign emit_go      = out_free && (cycle_hit || state_r == S_SUM ||
                        (state_r == S_EMIT &&
                         nout_r < (SW+1)'(ckm_pkg::MaxResults - 1)));

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready && in_ch.data.opcode == ckm_pkg::OpLoad) begin
      ea_mem[in_ch.data.slot] <= in_ch.data.end_a;
      eb_mem[in_ch.data.slot] <= in_ch.data.end_b;
      w_mem[in_ch.data.slot]  <= in_ch.data.weight;
      f_mem[in_ch.data.slot]  <= in_ch.data.must_use;
      b_mem[in_ch.data.slot]  <= in_ch.data.excluded;
    end
    ea_q_r <= ea_mem[slot_i];
    eb_q_r <= eb_mem[slot_i];
    w_q_r  <= w_mem[slot_i];
    f_q_r  <= f_mem[slot_i];
    b_q_r  <= b_mem[slot_i];
  end

  always_ff @(posedge clk) begin
    par_q_r <= par_mem[cur_r];
    sa_q_r  <= size_mem[root_a_r];
    sb_q_r  <= size_mem[start_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= VW'(1);
      ecount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ckm_pkg::CfgVertexCount: vcount_r <= cfg_data;
          ckm_pkg::CfgEdgeCount:   ecount_r <= cfg_data;
          default: ;
        endcase
      end
      if (emit_go) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready && in_ch.data.opcode == ckm_pkg::OpRun) begin
            nv_r <= (vcount_r == '0) ? VW'(1) :
                    (vcount_r > VW'(ckm_pkg::MaxVertices)) ? VW'(ckm_pkg::MaxVertices)
                    : vcount_r;
            ne_r <= (ecount_r > VW'(ckm_pkg::MaxEdges)) ? VW'(ckm_pkg::MaxEdges)
                    : ecount_r;
            cur_r    <= '0;
            cost_r   <= '0;
            tcount_r <= '0;
            nout_r   <= '0;
            idx_r    <= '0;
            pass_r   <= 1'b0;
            state_r  <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          // one union-find entry a cycle
          par_mem[cur_r]  <= cur_r;
          size_mem[cur_r] <= VW'(1);
          if (cur_r == VW'(ckm_pkg::MaxVertices)) state_r <= S_FETCH;
          else cur_r <= cur_r + VW'(1);
        end
        S_FETCH: begin
          if (idx_r >= (SW+1)'(ne_r)) begin
            if (pass_r) state_r <= S_SUM;
            else begin
              pass_r <= 1'b1;
              idx_r  <= '0;
            end
          end else state_r <= S_EDGE;
        end
        S_EDGE: begin
          if ((!pass_r && !f_q_r) || (pass_r && (f_q_r || b_q_r)) ||
              ea_q_r > nv_r || eb_q_r > nv_r) begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_FETCH;
          end else begin
            eb_r      <= eb_q_r;
            w_r       <= w_q_r;
            cur_r     <= ea_q_r;
            start_r   <= ea_q_r;
            which_r   <= 1'b0;
            rd_wait_r <= 1'b1;
            state_r   <= S_FIND_UP;
          end
        end
        S_FIND_UP: begin
          // climb to the root, then walk again from the start pointing at it
          if (rd_wait_r) rd_wait_r <= 1'b0;
          else if (par_q_r == cur_r) begin
            root_a_r  <= which_r ? root_a_r : cur_r;
            start_r   <= cur_r;
            cur_r     <= start_r;
            rd_wait_r <= 1'b1;
            state_r   <= S_FIND_CMP;
          end else begin
            cur_r     <= par_q_r;
            rd_wait_r <= 1'b1;
          end
        end
        S_FIND_CMP: begin
          // start_r holds the root here
          if (rd_wait_r) rd_wait_r <= 1'b0;
          else if (par_q_r == start_r || cur_r == start_r) begin
            if (!which_r) begin
              which_r   <= 1'b1;
              cur_r     <= eb_r;
              start_r   <= eb_r;
              rd_wait_r <= 1'b1;
              state_r   <= S_FIND_UP;
            end else state_r <= S_UNION;
          end else begin
            par_mem[cur_r] <= start_r;
            cur_r          <= par_q_r;
            rd_wait_r      <= 1'b1;
          end
        end
        S_UNION: begin
          if (root_a_r == start_r) begin
            if (!pass_r) begin
              // hold until any pending edge word has gone
              if (out_free) begin
                out_r   <= '{edge_slot: '0, total_cost: cost_r,
                             status: ckm_pkg::StatCycle, last: 1'b1};
                state_r <= S_WAIT;
              end
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_FETCH;
            end
          end else begin
            if (sa_q_r < sb_q_r) begin
              par_mem[root_a_r] <= start_r;
              size_mem[start_r] <= sb_q_r + sa_q_r;
            end else begin
              par_mem[start_r]   <= root_a_r;
              size_mem[root_a_r] <= sa_q_r + sb_q_r;
            end
            cost_r   <= (csum[CW] != csum[CW-1]) ? (csum[CW] ? CostMin : CostMax)
                        : csum[CW-1:0];
            tcount_r <= tcount_r + VW'(1);
            state_r  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (nout_r < (SW+1)'(ckm_pkg::MaxResults - 1)) begin
            if (out_free) begin
              out_r   <= '{edge_slot: slot_i, total_cost: '0,
                           status: ckm_pkg::StatOk, last: 1'b0};
              nout_r  <= nout_r + 1'b1;
              idx_r   <= idx_r + 1'b1;
              state_r <= S_FETCH;
            end
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_FETCH;
          end
        end
        S_SUM: begin
          if (out_free) begin
            out_r   <= '{edge_slot: '0, total_cost: cost_r,
                         status: (tcount_r == nv_r - VW'(1)) ? ckm_pkg::StatOk
                                 : ckm_pkg::StatNoSpan,
                         last: 1'b1};
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (out_valid_r && out_ch.ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `CKM_ASSERT(a_ready_idle, in_ch.ready, state_r == S_IDLE && !out_valid_r,
              "ready outside idle")
  `CKM_ASSERT(a_last_cost, out_ch.valid && !out_ch.data.last, out_ch.data.total_cost == '0,
              "edge word carries cost")
  `CKM_ASSERT_NEXT(a_run_leaves_idle,
                   in_ch.valid && in_ch.ready && in_ch.data.opcode == ckm_pkg::OpRun,
                   state_r == S_CLEAR, "run did not start clear")
  `CKM_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready,
                   out_ch.valid && $stable(out_ch.data), "out word dropped or changed")
endmodule

### sim/constrained_kruskal_mst_top_tb.sv
// Testbench for constrained_kruskal_mst_top: loads edge slots, runs tree builds
// and checks every result word against a built-in Kruskal/union-find predictor.
// Depends on ckm_pkg, ckm_if and the design top level.
module constrained_kruskal_mst_top_tb;

  class tree_predictor;
    logic [6:0]  edge_a [ckm_pkg::MaxEdges];
    logic [6:0]  edge_b [ckm_pkg::MaxEdges];
    longint      edge_w [ckm_pkg::MaxEdges];
    bit          edge_forced [ckm_pkg::MaxEdges];
    bit          edge_banned [ckm_pkg::MaxEdges];
    logic [6:0]  vertex_reg = 7'd1;
    logic [6:0]  edge_reg = 7'd0;
    int          parent [ckm_pkg::MaxVertices + 1];
    int          set_sz [ckm_pkg::MaxVertices + 1];
    longint      cost;
    int          joined;
    ckm_pkg::out_word_t expected_tree [$];
    int          errors = 0;

    function void set_reg(logic idx, logic [6:0] value);
      if (idx == ckm_pkg::CfgVertexCount) vertex_reg = value;
      else edge_reg = value;
    endfunction

    function int find_root(int v);
      int r;
      int nx;
      r = v;
      while (parent[r] != r) r = parent[r];
      while (parent[v] != r) begin
        nx = parent[v];
        parent[v] = r;
        v = nx;
      end
      return r;
    endfunction

    // 1 joined, 0 same set, -1 endpoint beyond the vertex range
    function int join_sets(int a, int b, int nv);
      int t;
      if (a > nv || b > nv) return -1;
      a = find_root(a);
      b = find_root(b);
      if (a == b) return 0;
      if (set_sz[a] < set_sz[b]) begin
        t = a; a = b; b = t;
      end
      parent[b] = a;
      set_sz[a] = set_sz[a] + set_sz[b];
      return 1;
    endfunction

    function void add_weight(longint w);
      cost = cost + w;
      if (cost > 64'sd549755813887) cost = 64'sd549755813887;
      if (cost < -64'sd549755813888) cost = -64'sd549755813888;
      joined++;
    endfunction

    function void push_word(int slot, longint c, logic [1:0] st, bit lst);
      ckm_pkg::out_word_t o;
      o.edge_slot = slot[ckm_pkg::SW-1:0];
      o.total_cost = c[ckm_pkg::CW-1:0];
      o.status = st;
      o.last = lst;
      expected_tree = {expected_tree, o};
    endfunction

    function void note_word(ckm_pkg::in_word_t w);
      int nv;
      int ne;
      int n;
      int r;
      if (w.opcode == ckm_pkg::OpLoad) begin
        edge_a[w.slot] = w.end_a;
        edge_b[w.slot] = w.end_b;
        edge_w[w.slot] = longint'(w.weight);
        edge_forced[w.slot] = w.must_use;
        edge_banned[w.slot] = w.excluded;
        return;
      end
      nv = vertex_reg;
      if (nv < 1) nv = 1;
      if (nv > ckm_pkg::MaxVertices) nv = ckm_pkg::MaxVertices;
      ne = edge_reg;
      if (ne > ckm_pkg::MaxEdges) ne = ckm_pkg::MaxEdges;
      for (int i = 0; i <= ckm_pkg::MaxVertices; i++) begin
        parent[i] = i;
        set_sz[i] = 1;
      end
      cost = 0;
      joined = 0;
      n = 0;
      for (int i = 0; i < ne; i++) begin
        if (!edge_forced[i]) continue;
        r = join_sets(edge_a[i], edge_b[i], nv);
        if (r == 0) begin
          push_word(0, cost, ckm_pkg::StatCycle, 1'b1);
          return;
        end
        if (r < 0) continue;
        add_weight(edge_w[i]);
        if (n < ckm_pkg::MaxResults - 1) begin
          push_word(i, 0, ckm_pkg::StatOk, 1'b0);
          n++;
        end
      end
      for (int i = 0; i < ne; i++) begin
        if (edge_forced[i] || edge_banned[i]) continue;
        if (join_sets(edge_a[i], edge_b[i], nv) != 1) continue;
        add_weight(edge_w[i]);
        if (n < ckm_pkg::MaxResults - 1) begin
          push_word(i, 0, ckm_pkg::StatOk, 1'b0);
          n++;
        end
      end
      push_word(0, cost, (joined == nv - 1) ? ckm_pkg::StatOk : ckm_pkg::StatNoSpan, 1'b1);
    endfunction

    function void check_word(ckm_pkg::out_word_t got);
      ckm_pkg::out_word_t exp_w;
      if (expected_tree.size() == 0) begin
        $display("%0t: unexpected word %p", $time, got);
        errors++;
        return;
      end
      exp_w = expected_tree.pop_front();
      if (got.edge_slot !== exp_w.edge_slot) begin
        $display("%0t: edge_slot exp %0d got %0d", $time, exp_w.edge_slot, got.edge_slot);
        errors++;
      end
      if (got.total_cost !== exp_w.total_cost) begin
        $display("%0t: total_cost exp %0d got %0d", $time, exp_w.total_cost,
                 got.total_cost);
        errors++;
      end
      if (got.status !== exp_w.status) begin
        $display("%0t: status exp %0d got %0d", $time, exp_w.status, got.status);
        errors++;
      end
      if (got.last !== exp_w.last) begin
        $display("%0t: last exp %0b got %0b", $time, exp_w.last, got.last);
        errors++;
      end
    endfunction
  endclass

  localparam int StallLimit = 40000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic [6:0] cfg_data = 7'd0;

  ckm_in_if  in_ch ();
  ckm_out_if out_ch ();

  constrained_kruskal_mst_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  tree_predictor tree_pred = new();
  int     words_sent = 0;
  int     burst_left = 0;
  int     ready_pct = 100;
  int     idle_cycles = 0;
  longint ramp_w;

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) < ready_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) tree_pred.check_word(out_ch.data);
  end

  // Watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_word(ckm_pkg::in_word_t w);
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.data = w;
    do @(posedge clk); while (!in_ch.ready);
    tree_pred.note_word(w);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
  endtask

  task automatic load_edge(int slot, int a, int b, longint w, bit f, bit x);
    ckm_pkg::in_word_t wd;
    wd.opcode = ckm_pkg::OpLoad;
    wd.slot = slot[ckm_pkg::SW-1:0];
    wd.end_a = a[ckm_pkg::VW-1:0];
    wd.end_b = b[ckm_pkg::VW-1:0];
    wd.weight = w[31:0];
    wd.must_use = f;
    wd.excluded = x;
    send_word(wd);
  endtask

  task automatic start_build();
    ckm_pkg::in_word_t wd;
    logic [63:0] rnd;
    rnd = {$urandom, $urandom};
    wd = rnd[$bits(ckm_pkg::in_word_t)-1:0];
    wd.opcode = ckm_pkg::OpRun;
    send_word(wd);
  endtask

  // Hold until every expected word is out and any load has settled
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (tree_pred.expected_tree.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] value);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    tree_pred.set_reg(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_endpoint(int nv, output int v);
    int p;
    p = $urandom_range(0, 19);
    if (p == 0) v = 0;
    else if (p == 1) v = $urandom_range(0, 64);
    else v = $urandom_range(1, nv);
  endtask

  task automatic random_phase();
    int nv;
    int ne;
    int a;
    int b;
    bit sorted;
    longint w;
    nv = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 64) : $urandom_range(2, 12);
    ne = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 16);
    ready_pct = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(20, 90);
    write_reg(ckm_pkg::CfgVertexCount, nv[6:0]);
    write_reg(ckm_pkg::CfgEdgeCount, ne[6:0]);
    sorted = ($urandom_range(0, 4) != 0);
    w = longint'($signed($urandom)) >>> $urandom_range(0, 31);
    for (int s = 0; s < ne; s++) begin
      random_endpoint(nv, a);
      random_endpoint(nv, b);
      if (sorted) begin
        w = w + $urandom_range(0, 1000);
        if (w > 64'sd2147483647) w = 64'sd2147483647;
      end else begin
        w = longint'($signed($urandom));
      end
      load_edge(s, a, b, w, ($urandom_range(0, 9) == 0), ($urandom_range(0, 5) == 0));
    end
    start_build();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fill every slot so no run ever reads an unwritten entry; extremes at the ends
    ramp_w = -64'sd2147483648;
    for (int s = 0; s < ckm_pkg::MaxEdges; s++) begin
      if (s == ckm_pkg::MaxEdges - 1) ramp_w = 64'sd2147483647;
      load_edge(s, $urandom_range(1, 64), $urandom_range(1, 64), ramp_w,
                1'b0, ($urandom_range(0, 7) == 0));
      ramp_w = ramp_w + 64'sd67108864;
    end

    // Default registers: one vertex, no edges
    start_build();
    // Clamped registers: vertex count zero, edge count beyond range
    write_reg(ckm_pkg::CfgVertexCount, 7'd0);
    write_reg(ckm_pkg::CfgEdgeCount, 7'd127);
    start_build();
    write_reg(ckm_pkg::CfgVertexCount, 7'd127);
    start_build();
    write_reg(ckm_pkg::CfgVertexCount, 7'd64);
    write_reg(ckm_pkg::CfgEdgeCount, 7'd64);
    start_build();

    // Forced edges, forced and banned together, out-of-range and vertex zero edges
    write_reg(ckm_pkg::CfgVertexCount, 7'd4);
    write_reg(ckm_pkg::CfgEdgeCount, 7'd6);
    load_edge(0, 1, 2, -64'sd2147483648, 1'b1, 1'b1);
    load_edge(1, 2, 3, -5, 1'b0, 1'b0);
    load_edge(2, 3, 9, 0, 1'b1, 1'b0);
    load_edge(3, 0, 4, 7, 1'b0, 1'b0);
    load_edge(4, 3, 4, 8, 1'b0, 1'b1);
    load_edge(5, 4, 1, 64'sd2147483647, 1'b0, 1'b0);
    start_build();
    // Forced cycle stops the build
    load_edge(3, 2, 1, 9, 1'b1, 1'b0);
    start_build();

    while (words_sent < 270) random_phase();

    drain();
    repeat (200) @(posedge clk);
    if (tree_pred.errors == 0 && tree_pred.expected_tree.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

### files.f
+incdir+design
design/ckm_pkg.sv
design/ckm_if.sv
design/constrained_kruskal_mst_top.sv
sim/constrained_kruskal_mst_top_tb.sv
